>>> sv/clipped_box_blur_rgb_top_assert.svh
// Assertion macros shared by the checker of the clipped box blur block.
`ifndef CLIPPED_BOX_BLUR_RGB_TOP_ASSERT_SVH
`define CLIPPED_BOX_BLUR_RGB_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBB_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cbb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CBB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cbb assertion failed");

`endif

>>> sv/cbb_pkg.sv
// Package with constants and payload types of the clipped box blur block.
`default_nettype none
package cbb_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int MAX_RADIUS   = 31;
  localparam int RESET_RADIUS = 20;

  localparam int CH_W   = 8;
  localparam int CFG_W  = 9;
  localparam int RAD_W  = 5;
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int WIN    = 2 * MAX_RADIUS + 1;
  localparam int CNT_W  = $clog2(WIN * WIN + 1);
  localparam int SUM_W  = $clog2(WIN * WIN * 255 + 1);

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef struct packed {
    logic            func;
    logic [7:0]      pixel_row;
    logic [7:0]      pixel_col;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            query_status;
  } out_item_t;

endpackage
`default_nettype wire

>>> sv/clipped_box_blur_rgb_top.sv
// Top level of the clipped box blur block with frame store and sequencer.
`default_nettype none
// A write request stores one pixel in the frame store. A query request passes a setup state,
// then reads the window pixels that lie inside the image, one per cycle, through the single
// port of the frame store (at most (2*radius+1)^2, 1681 at the reset radius of 20), passes a
// drain state, the shared 8-step restoring divider for the three channels and the load of the
// output register, which waits while an earlier result is still held. A query outside the image
// goes from setup straight to that load. The block takes no new request while a query is in
// work. The frame store needs no clearing pass: only written entries may be read.
module clipped_box_blur_rgb_top (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  cbb_pkg::in_item_t           in_item_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output cbb_pkg::out_item_t                out_item_o,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [cbb_pkg::APB_AW-1:0]        paddr,
  input  wire  [cbb_pkg::APB_DW-1:0]        pwdata,
  output logic [cbb_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);
  import cbb_pkg::*;

  localparam int RC_W = ((ROW_W > RAD_W) ? ROW_W : RAD_W) + 1;
  localparam int CC_W = ((COL_W > RAD_W) ? COL_W : RAD_W) + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DLOAD = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [CFG_W-1:0]  image_width_q, image_height_q;
  logic [RAD_W-1:0]  blur_radius_q;
  logic [2:0]        state_q, state_d;
  in_item_t          qry_q;
  logic              range_err_q;
  logic [ROW_W-1:0]  r_q, r_hi_q;
  logic [COL_W-1:0]  c_q, c_lo_q, c_hi_q;
  logic              rd_vld_q;
  logic [3*CH_W-1:0] rd_data_q;
  logic [3*CH_W-1:0] mem [2**ADDR_W];
  logic [SUM_W-1:0]  sum_r_q, sum_g_q, sum_b_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SUM_W-1:0]  rem_q;
  logic [CH_W-1:0]   quo_q;
  logic [2:0]        bit_q;
  logic [1:0]        ch_q;
  logic [CH_W-1:0]   res_q [3];
  logic              out_valid_q;
  out_item_t         out_q;

  logic              cfg_wr, in_acc, out_load;
  logic [ROW_W:0]    h_eff;
  logic [COL_W:0]    w_eff;
  logic [RAD_W-1:0]  rad_eff;
  logic [RC_W-1:0]   row_x, rad_rx, r_sum, r_lo, r_hi, h_m1;
  logic [CC_W-1:0]   col_x, rad_cx, c_sum, c_lo, c_hi, w_m1;
  logic              outside;
  logic              last_col, last_row;
  logic [SUM_W-1:0]  trial, sum_sel;
  logic              trial_ge;

  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_load    = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_WIDTH:  prdata = APB_DW'(image_width_q);
      REG_HEIGHT: prdata = APB_DW'(image_height_q);
      REG_RADIUS: prdata = APB_DW'(blur_radius_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= CFG_W'(MAX_WIDTH);
      image_height_q <= CFG_W'(MAX_HEIGHT);
      blur_radius_q  <= RAD_W'(RESET_RADIUS);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_WIDTH:  image_width_q  <= pwdata[CFG_W-1:0];
        REG_HEIGHT: image_height_q <= pwdata[CFG_W-1:0];
        REG_RADIUS: blur_radius_q  <= pwdata[RAD_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (image_height_q == '0) begin
      h_eff = (ROW_W+1)'(1);
    end else if (32'(image_height_q) > MAX_HEIGHT) begin
      h_eff = (ROW_W+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (ROW_W+1)'(image_height_q);
    end
    if (image_width_q == '0) begin
      w_eff = (COL_W+1)'(1);
    end else if (32'(image_width_q) > MAX_WIDTH) begin
      w_eff = (COL_W+1)'(MAX_WIDTH);
    end else begin
      w_eff = (COL_W+1)'(image_width_q);
    end
    if (32'(blur_radius_q) > MAX_RADIUS) begin
      rad_eff = RAD_W'(MAX_RADIUS);
    end else begin
      rad_eff = blur_radius_q;
    end
  end

  always_comb begin
    row_x   = RC_W'(qry_q.pixel_row);
    rad_rx  = RC_W'(rad_eff);
    h_m1    = RC_W'(h_eff - 1'b1);
    r_sum   = row_x + rad_rx;
    r_lo    = (row_x >= rad_rx) ? (row_x - rad_rx) : '0;
    r_hi    = (r_sum > h_m1) ? h_m1 : r_sum;
    col_x   = CC_W'(qry_q.pixel_col);
    rad_cx  = CC_W'(rad_eff);
    w_m1    = CC_W'(w_eff - 1'b1);
    c_sum   = col_x + rad_cx;
    c_lo    = (col_x >= rad_cx) ? (col_x - rad_cx) : '0;
    c_hi    = (c_sum > w_m1) ? w_m1 : c_sum;
    outside = (32'(qry_q.pixel_row) >= 32'(h_eff)) || (32'(qry_q.pixel_col) >= 32'(w_eff));
  end

  assign last_col = (c_q == c_hi_q);
  assign last_row = (r_q == r_hi_q);
  assign trial    = SUM_W'(cnt_q) << bit_q;
  assign trial_ge = (rem_q >= trial);

  always_comb begin
    case (ch_q)
      2'd0:    sum_sel = sum_r_q;
      2'd1:    sum_sel = sum_g_q;
      default: sum_sel = sum_b_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc && in_item_i.func == FUNC_QUERY) state_d = S_SETUP;
      S_SETUP: state_d = outside ? S_FIN : S_SCAN;
      S_SCAN:  if (last_col && last_row) state_d = S_DRAIN;
      S_DRAIN: state_d = S_DLOAD;
      S_DLOAD: state_d = S_DIV;
      S_DIV: begin
        if (bit_q == '0) state_d = (ch_q == 2'd2) ? S_FIN : S_DLOAD;
      end
      S_FIN:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == S_SCAN);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_item_i.func == FUNC_WRITE) begin
      mem[{in_item_i.pixel_row[ROW_W-1:0], in_item_i.pixel_col[COL_W-1:0]}] <=
        {in_item_i.in_red, in_item_i.in_green, in_item_i.in_blue};
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN) begin
      rd_data_q <= mem[{r_q, c_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      qry_q <= in_item_i;
    end
    case (state_q)
      S_SETUP: begin
        range_err_q <= outside;
        r_q         <= r_lo[ROW_W-1:0];
        r_hi_q      <= r_hi[ROW_W-1:0];
        c_q         <= c_lo[COL_W-1:0];
        c_lo_q      <= c_lo[COL_W-1:0];
        c_hi_q      <= c_hi[COL_W-1:0];
        sum_r_q     <= '0;
        sum_g_q     <= '0;
        sum_b_q     <= '0;
        cnt_q       <= '0;
        ch_q        <= 2'd0;
      end
      S_SCAN: begin
        if (last_col) begin
          c_q <= c_lo_q;
          r_q <= r_q + 1'b1;
        end else begin
          c_q <= c_q + 1'b1;
        end
      end
      S_DLOAD: begin
        rem_q <= sum_sel;
        quo_q <= '0;
        bit_q <= 3'd7;
      end
      S_DIV: begin
        if (trial_ge) begin
          rem_q        <= rem_q - trial;
          quo_q[bit_q] <= 1'b1;
        end
        if (bit_q == '0) begin
          res_q[ch_q] <= trial_ge ? (quo_q | CH_W'(1)) : quo_q;
          ch_q        <= ch_q + 1'b1;
        end else begin
          bit_q <= bit_q - 1'b1;
        end
      end
      default: ;
    endcase
    if (rd_vld_q) begin
      sum_r_q <= sum_r_q + SUM_W'(rd_data_q[3*CH_W-1:2*CH_W]);
      sum_g_q <= sum_g_q + SUM_W'(rd_data_q[2*CH_W-1:CH_W]);
      sum_b_q <= sum_b_q + SUM_W'(rd_data_q[CH_W-1:0]);
      cnt_q   <= cnt_q + 1'b1;
    end
    if (out_load) begin
      if (range_err_q) begin
        out_q.out_red      <= '0;
        out_q.out_green    <= '0;
        out_q.out_blue     <= '0;
        out_q.query_status <= STATUS_RANGE;
      end else begin
        out_q.out_red      <= res_q[0];
        out_q.out_green    <= res_q[1];
        out_q.out_blue     <= res_q[2];
        out_q.query_status <= STATUS_OK;
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/cbb_checker.sv
// Port checker of the clipped box blur block and its bind statement.
`default_nettype none
`include "clipped_box_blur_rgb_top_assert.svh"
module cbb_checker (
  input wire                         clk_i,
  input wire                         rst_ni,
  input wire                         in_valid_i,
  input wire                         in_ready_o,
  input wire cbb_pkg::in_item_t      in_item_i,
  input wire                         out_valid_o,
  input wire                         out_ready_i,
  input wire cbb_pkg::out_item_t     out_item_o,
  input wire                         psel,
  input wire                         pready
);
  import cbb_pkg::*;

  `CBB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `CBB_ASSERT_SAME(a_err_zero, clk_i, rst_ni, out_valid_o && out_item_o.query_status == STATUS_RANGE, out_item_o.out_red == '0 && out_item_o.out_green == '0 && out_item_o.out_blue == '0)
  `CBB_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, in_valid_i && in_ready_o && in_item_i.func == FUNC_QUERY, !in_ready_o)
  `CBB_ASSERT_SAME(a_pready, clk_i, rst_ni, psel, pready)

endmodule

bind clipped_box_blur_rgb_top cbb_checker u_cbb_checker (.*);
`default_nettype wire

>>> sim/testbench.sv
// Testbench for the clipped box blur block: directed and random requests against a local predictor.
`timescale 1ns / 1ps

module testbench;
  import cbb_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_item_t in_item = '0;
  logic out_ready = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;

  wire in_ready;
  wire out_valid;
  out_item_t out_item;
  wire [APB_DW-1:0] prdata;
  wire pready;

  logic [8:0] cfg_width = 9'd256;
  logic [8:0] cfg_height = 9'd256;
  logic [4:0] cfg_radius = 5'(RESET_RADIUS);
  logic [23:0] pixel_mem [MAX_WIDTH*MAX_HEIGHT];
  bit pixel_written [MAX_WIDTH*MAX_HEIGHT];
  out_item_t blur_expect_q[$];
  out_item_t blur_head;

  int items_sent = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_len = 0;

  clipped_box_blur_rgb_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk = ~clk;

  function automatic int clamp_dim(input logic [8:0] v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int window_radius();
    return (cfg_radius > MAX_RADIUS) ? MAX_RADIUS : cfg_radius;
  endfunction

  function automatic out_item_t predict_blur(input logic [7:0] row, input logic [7:0] col);
    int w, h, rad, r, c;
    int unsigned sum_r, sum_g, sum_b, cnt;
    logic [23:0] px;
    out_item_t res;
    w = clamp_dim(cfg_width, MAX_WIDTH);
    h = clamp_dim(cfg_height, MAX_HEIGHT);
    rad = window_radius();
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    cnt = 0;
    res = '0;
    if (row >= h || col >= w) begin
      res.query_status = STATUS_RANGE;
      return res;
    end
    for (r = int'(row) - rad; r <= int'(row) + rad; r++) begin
      for (c = int'(col) - rad; c <= int'(col) + rad; c++) begin
        if (r >= 0 && r < h && c >= 0 && c < w) begin
          px = pixel_mem[r * MAX_WIDTH + c];
          sum_r += px[23:16];
          sum_g += px[15:8];
          sum_b += px[7:0];
          cnt++;
        end
      end
    end
    res.out_red = 8'(sum_r / cnt);
    res.out_green = 8'(sum_g / cnt);
    res.out_blue = 8'(sum_b / cnt);
    res.query_status = STATUS_OK;
    return res;
  endfunction

  task automatic send_item(input in_item_t item);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (item.func == FUNC_QUERY) begin
      blur_expect_q.push_back(predict_blur(item.pixel_row, item.pixel_col));
    end else begin
      pixel_mem[{item.pixel_row, item.pixel_col}] = {item.in_red, item.in_green, item.in_blue};
      pixel_written[{item.pixel_row, item.pixel_col}] = 1'b1;
    end
    items_sent++;
  endtask

  task automatic write_pixel(input logic [7:0] row, input logic [7:0] col,
                             input logic [23:0] rgb);
    in_item_t item;
    item.func = FUNC_WRITE;
    item.pixel_row = row;
    item.pixel_col = col;
    {item.in_red, item.in_green, item.in_blue} = rgb;
    send_item(item);
  endtask

  // Every in-image pixel of the window is written before the query that reads it.
  task automatic query_pixel(input logic [7:0] row, input logic [7:0] col);
    int w, h, rad, r, c;
    in_item_t item;
    w = clamp_dim(cfg_width, MAX_WIDTH);
    h = clamp_dim(cfg_height, MAX_HEIGHT);
    rad = window_radius();
    if (row < h && col < w) begin
      for (r = int'(row) - rad; r <= int'(row) + rad; r++) begin
        for (c = int'(col) - rad; c <= int'(col) + rad; c++) begin
          if (r >= 0 && r < h && c >= 0 && c < w && !pixel_written[r * MAX_WIDTH + c]) begin
            write_pixel(8'(r), 8'(c), 24'($urandom()));
          end
        end
      end
    end
    item.func = FUNC_QUERY;
    item.pixel_row = row;
    item.pixel_col = col;
    {item.in_red, item.in_green, item.in_blue} = 24'($urandom());
    send_item(item);
  endtask

  task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (reg_idx)
      REG_WIDTH: cfg_width = data[8:0];
      REG_HEIGHT: cfg_height = data[8:0];
      REG_RADIUS: cfg_radius = data[4:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (blur_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] random_dim();
    logic [31:0] v;
    case ($urandom_range(9))
      0: v = 32'd0;
      1: v = 32'd256;
      2: v = $urandom_range(511, 257);
      default: v = $urandom_range(12, 1);
    endcase
    if ($urandom_range(3) == 0) v = v | ($urandom() & 32'hFFFF_FE00);
    return v;
  endfunction

  task automatic run_random_phase(input int n_items);
    int w, h, first;
    logic [31:0] rad;
    wait_results_done();
    apb_write(REG_WIDTH, random_dim());
    apb_write(REG_HEIGHT, random_dim());
    w = clamp_dim(cfg_width, MAX_WIDTH);
    h = clamp_dim(cfg_height, MAX_HEIGHT);
    if (w > 16 || h > 16) begin
      rad = $urandom_range(2);
    end else begin
      case ($urandom_range(3))
        0: rad = MAX_RADIUS;
        1: rad = $urandom_range(MAX_RADIUS);
        default: rad = $urandom_range(4);
      endcase
    end
    if ($urandom_range(3) == 0) rad = rad | ($urandom() & 32'hFFFF_FFE0);
    apb_write(REG_RADIUS, rad);
    first = items_sent;
    while (items_sent - first < n_items) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: query_pixel(8'($urandom_range(h - 1)), 8'($urandom_range(w - 1)));
        5: query_pixel(8'($urandom_range(255)), 8'($urandom_range(255)));
        6, 7: write_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), 24'($urandom()));
        default: write_pixel(8'($urandom_range(h - 1)), 8'($urandom_range(w - 1)),
                             24'($urandom()));
      endcase
    end
  endtask

  task automatic test_reset_config();
    int c;
    apb_write(REG_HEIGHT, 32'd1);
    for (c = 235; c <= 255; c++) begin
      write_pixel(0, 8'(c), (c == 255) ? 24'hFFFFFF : (c[0] ? 24'hFF00FF : 24'h00FF00));
    end
    query_pixel(0, 255);
    query_pixel(1, 0);
  endtask

  task automatic test_register_extremes();
    wait_results_done();
    apb_write(REG_UNUSED, 32'h0000_0005);
    apb_write(REG_WIDTH, 32'hFFFF_FE00);
    apb_write(REG_HEIGHT, 32'h0000_0203);
    apb_write(REG_RADIUS, 32'hFFFF_FFFF);
    write_pixel(0, 0, 24'h80FF01);
    write_pixel(1, 0, 24'hFFFFFF);
    write_pixel(2, 0, 24'h000000);
    query_pixel(2, 0);
    query_pixel(0, 1);
    query_pixel(3, 0);
    query_pixel(255, 255);
    wait_results_done();
    apb_write(REG_RADIUS, 32'd0);
    query_pixel(1, 0);
    wait_results_done();
    apb_write(REG_WIDTH, 32'h0000_01FF);
    apb_write(REG_HEIGHT, 32'h0000_0100);
    write_pixel(255, 255, 24'hFFFFFF);
    query_pixel(255, 255);
    query_pixel(0, 255);
  endtask

  task automatic test_output_backpressure();
    int k;
    wait_results_done();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    apb_write(REG_WIDTH, 32'd4);
    apb_write(REG_HEIGHT, 32'd4);
    apb_write(REG_RADIUS, 32'd1);
    for (k = 0; k < 16; k++) write_pixel(8'(k / 4), 8'(k % 4), 24'($urandom()));
    hold_off_len = 300;
    for (k = 0; k < 8; k++) query_pixel(8'(k % 4), 8'(3 - k % 4));
    wait_results_done();
    for (k = 0; k < 4; k++) query_pixel(8'($urandom_range(3)), 8'($urandom_range(3)));
  endtask

  task automatic test_random_no_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random_phase(30);
    run_random_phase(30);
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct = 52;
    recv_stall_pct = 0;
    run_random_phase(30);
    run_random_phase(30);
  endtask

  task automatic test_random_receiver_stall();
    send_idle_pct = 0;
    recv_stall_pct = 52;
    run_random_phase(30);
    run_random_phase(30);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct = 10;
    recv_stall_pct = 10;
    run_random_phase(30);
    run_random_phase(30);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(negedge clk) begin
    if (hold_off_len > 0) begin
      hold_off_len = hold_off_len - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (blur_expect_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_item);
        mismatch_count++;
      end else begin
        blur_head = blur_expect_q.pop_front();
        check_field("out_red", blur_head.out_red, out_item.out_red);
        check_field("out_green", blur_head.out_green, out_item.out_green);
        check_field("out_blue", blur_head.out_blue, out_item.out_blue);
        check_field("query_status", 8'(blur_head.query_status), 8'(out_item.query_status));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_config();
    test_register_extremes();
    test_output_backpressure();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    wait_results_done();
    if (mismatch_count == 0 && blur_expect_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
